>>> rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the q24.8 fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9
    } t_opcode;

    // per-word side data carried alongside the long arithmetic units
    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] simple;
        logic                     dz;
        logic                     lt;
        logic                     eq;
        logic                     gt;
    } t_side;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     divide_by_zero;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               divide_by_zero;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;

    modport source (output valid, output result_value, output divide_by_zero,
                    output a_less, output a_equal, output a_greater, input ready);
    modport sink   (input valid, input result_value, input divide_by_zero,
                    input a_less, input a_equal, input a_greater, output ready);
endinterface

`default_nettype wire

>>> rtl/core/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// signed q24.8 fixed-point alu with comparison flags
//
//   channel   dir   contents
//   i_in      in    opcode, operand_a, operand_b
//   o_out     out   result_value, divide_by_zero, a_less, a_equal, a_greater
//
// one word per cycle while the skid register is empty; the divider resolves one
// quotient bit per stage over 32 + FRAC_BITS stages.
// reset clears the valid bits of the pipeline and of the output stage.
// the output has a skid register; the pipeline holds while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fpa_in_if.sink     i_in,
    fpa_out_if.source  o_out
);

    localparam int LAT = DATA_W + FRAC_BITS + 2;

    logic en;
    logic r_vld [0:LAT-1];
    t_side r_side [0:LAT-1];
    logic signed [DATA_W-1:0] r_mul [0:LAT-3];
    logic signed [DATA_W-1:0] mul_out;
    logic signed [DATA_W-1:0] div_out;

    t_side   n_side;
    t_result p_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    push;

    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;

    assign en         = ~r_skid_valid;
    assign i_in.ready = en;
    assign a          = i_in.operand_a;
    assign b          = i_in.operand_b;

    always_comb begin
        n_side        = '0;
        n_side.opcode = i_in.opcode;
        n_side.lt     = a < b;
        n_side.eq     = a == b;
        n_side.gt     = a > b;
        case (t_opcode'(i_in.opcode))
            OP_ADD:      n_side.simple = a + b;
            OP_SUB:      n_side.simple = a - b;
            OP_DIV:      n_side.dz     = b == '0;
            OP_MIN:      n_side.simple = (a < b) ? a : b;
            OP_MAX:      n_side.simple = (a > b) ? a : b;
            OP_INC:      n_side.simple = a + 32'sd1;
            OP_DEC:      n_side.simple = a - 32'sd1;
            OP_TO_INT:   n_side.simple = a >>> FRAC_BITS;
            OP_FROM_INT: n_side.simple = a <<< FRAC_BITS;
            default:     n_side.simple = '0;
        endcase
    end

    fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_a       (a),
        .i_b       (b),
        .o_product (mul_out)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_a        (a),
        .i_b        (b),
        .o_quotient (div_out)
    );

    // side data and valid bits travel level with the dividers stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_mul[0] <= mul_out;
            for (int k = 1; k < LAT-2; k++) begin
                r_mul[k] <= r_mul[k-1];
            end
        end
    end

    always_comb begin
        p_res.divide_by_zero = r_side[LAT-1].dz;
        p_res.a_less         = r_side[LAT-1].lt;
        p_res.a_equal        = r_side[LAT-1].eq;
        p_res.a_greater      = r_side[LAT-1].gt;
        case (t_opcode'(r_side[LAT-1].opcode))
            OP_MUL:  p_res.result_value = r_mul[LAT-3];
            OP_DIV:  p_res.result_value = r_side[LAT-1].dz ? '0 : div_out;
            default: p_res.result_value = r_side[LAT-1].simple;
        endcase
    end

    assign push = en & r_vld[LAT-1];

    // output word and skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : p_res;
        end else if (push) begin
            r_skid <= p_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_out.result_value;
    assign o_out.divide_by_zero = r_out.divide_by_zero;
    assign o_out.a_less         = r_out.a_less;
    assign o_out.a_equal        = r_out.a_equal;
    assign o_out.a_greater      = r_out.a_greater;

endmodule

`default_nettype wire

>>> rtl/core/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// two-stage signed multiplier with fixed-point rescale
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_mul
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_a,
    input  wire logic signed [DATA_W-1:0] i_b,
    output      logic signed [DATA_W-1:0] o_product
);

    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0]   r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_res  <= r_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    end

    assign o_product = r_res;

endmodule

`default_nettype wire

>>> rtl/core/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// pipelined restoring divider, (a << frac) / b truncated toward zero
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_a,
    input  wire logic signed [DATA_W-1:0] i_b,
    output      logic signed [DATA_W-1:0] o_quotient
);

    localparam int DW = DATA_W + FRAC_BITS;

    logic [DW-1:0]     r_q   [0:DW];
    logic [DATA_W-1:0] r_rem [0:DW];
    logic [DATA_W-1:0] r_d   [0:DW];
    logic              r_neg [0:DW];
    logic [DATA_W-1:0] r_quo;

    logic [DW-1:0] num;

    assign num = {i_a, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]   <= i_a[DATA_W-1] ? (~num + 1'b1) : num;
            r_rem[0] <= '0;
            r_d[0]   <= i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
            r_neg[0] <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
        end
    end

    for (genvar i = 0; i < DW; i++) begin : g_step
        logic [DATA_W:0]   trial;
        logic [DATA_W:0]   diff;
        logic              ge;

        assign trial = {r_rem[i], r_q[i][DW-1]};
        assign diff  = trial - {1'b0, r_d[i]};
        assign ge    = ~diff[DATA_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                r_q[i+1]   <= {r_q[i][DW-2:0], ge};
                r_d[i+1]   <= r_d[i];
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_neg[DW] ? (~r_q[DW][DATA_W-1:0] + 1'b1) : r_q[DW][DATA_W-1:0];
        end
    end

    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> test/tb_fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// self-checking bench for the q24.8 alu: directed corner words, then random
// words with random gaps and output stalls, checked in order by a scoreboard
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_point_alu_q24_8;
    import fpa_pkg::*;

    localparam int FRAC    = 8;
    localparam int LATENCY = FRAC + 35;
    localparam int LIMIT   = 400000;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   cycle_count = 0;
    int   stall_left;

    fpa_in_if  in_ch ();
    fpa_out_if out_ch ();

    fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    function automatic t_result alu_result(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
        t_result r;
        logic signed [63:0] wide;
        r = '0;
        case (op)
            OP_ADD:      r.result_value = a + b;
            OP_SUB:      r.result_value = a - b;
            OP_MUL: begin
                wide = 64'(a) * 64'(b);
                r.result_value = 32'(wide >>> FRAC);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    wide = (64'(a) <<< FRAC) / 64'(b);
                    r.result_value = 32'(wide);
                end
            end
            OP_MIN:      r.result_value = (a < b) ? a : b;
            OP_MAX:      r.result_value = (a > b) ? a : b;
            OP_INC:      r.result_value = a + 32'sd1;
            OP_DEC:      r.result_value = a - 32'sd1;
            OP_TO_INT:   r.result_value = a >>> FRAC;
            OP_FROM_INT: r.result_value = a <<< FRAC;
            default:     r.result_value = '0;
        endcase
        r.a_less    = a < b;
        r.a_equal   = a == b;
        r.a_greater = a > b;
        return r;
    endfunction

    class result_board;
        t_result pending[$];

        function void note_word(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
            pending.push_back(alu_result(op, a, b));
        endfunction

        task check_word(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("unexpected word", 64'(got), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report("result_value", 64'(got.result_value), 64'(want.result_value));
            if (got.divide_by_zero !== want.divide_by_zero)
                report("divide_by_zero", 64'(got.divide_by_zero), 64'(want.divide_by_zero));
            if (got.a_less !== want.a_less)
                report("a_less", 64'(got.a_less), 64'(want.a_less));
            if (got.a_equal !== want.a_equal)
                report("a_equal", 64'(got.a_equal), 64'(want.a_equal));
            if (got.a_greater !== want.a_greater)
                report("a_greater", 64'(got.a_greater), 64'(want.a_greater));
        endtask
    endclass

    result_board board;
    bit hold_off;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return 32'($urandom_range(0, 2000)) - 32'sd1000;
            4: return 32'($urandom_range(0, 65535)) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // output side: random stalls, now and then a long one, plus a hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                board.check_word({out_ch.result_value, out_ch.divide_by_zero,
                                  out_ch.a_less, out_ch.a_equal, out_ch.a_greater});
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else if ($urandom_range(0, 99) < 3) begin
                out_ch.ready <= 1'b0;
                stall_left   <= $urandom_range(8, 40);
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic [3:0] op, input logic signed [31:0] a,
                             input logic signed [31:0] b, input int gap);
        int k;
        for (k = 0; k < gap; k++) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_word(op, a, b);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    initial begin
        logic signed [31:0] edges[6];
        int i, j;
        board       = new();
        err_count   = 0;
        hold_off    = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        edges = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd256, 32'sd256, 32'sd1};
        for (i = 0; i < 16; i++)
            send_word(i[3:0], edges[i % 6], edges[(i + 2) % 6], 0);
        send_word(OP_DIV, 32'sd1000, 32'sd0, 0);
        send_word(OP_DIV, 32'sh8000_0000, -32'sd1, 0);
        send_word(OP_DIV, -32'sd700, 32'sd3, 0);
        send_word(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_word(OP_TO_INT, -32'sd1, 32'sd0, 0);
        send_word(OP_MIN, 32'sd5, 32'sd5, 0);
        send_word(OP_INC, 32'sh7fff_ffff, 32'sd0, 0);
        send_word(OP_DEC, 32'sh8000_0000, 32'sd0, 0);

        // sender pauses until every result is back
        drain();

        // receiver holds off while words keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (j = 0; j < 80; j++)
                send_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand(), 0);
        join

        for (j = 0; j < 320; j++) begin
            logic [3:0] op;
            logic signed [31:0] a, b;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            send_word(op, a, b, (j % 100 < 30) ? 0 : gap_len());
        end

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_count == 0 && board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
